@@ hw/rtl/xor_message_frame_parser_unit_macros.svh @@
// Assertion helpers shared by the frame parser modules.
// Every check is sampled on the rising edge of clock and is off during reset.
`ifndef XOR_MESSAGE_FRAME_PARSER_UNIT_MACROS_SVH
`define XOR_MESSAGE_FRAME_PARSER_UNIT_MACROS_SVH

// The condition holds at every clock edge.
`define XMFP_ASSERT_HOLDS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("xmfp: invariant violated");

// When the trigger holds, the condition holds at the same edge.
`define XMFP_ASSERT_IMPLIES(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("xmfp: implication violated");

// When the trigger holds, the condition holds at the next edge.
`define XMFP_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("xmfp: next-cycle check violated");

`endif

@@ hw/rtl/xmfp_pkg.sv @@
package xmfp_pkg;

   // Field widths of the channels.
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CMD_W  = 40;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned ADDR_W = 24;
   localparam int unsigned POS_W  = 16;

   // Frame layout in bytes.
   localparam int unsigned CMD_BYTES    = 5;
   localparam int unsigned LEN_BYTES    = 2;
   localparam int unsigned ADDR_BYTES   = 3;
   localparam int unsigned CSUM_BYTES   = 1;
   localparam int unsigned HEADER_BYTES = CMD_BYTES + LEN_BYTES + ADDR_BYTES;
   localparam int unsigned MIN_FRAME    = HEADER_BYTES + CSUM_BYTES;

   // The byte position counter stops here.
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Default number of entries in the result queue.
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

   // Result kind codes.
   localparam logic KIND_BODY    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // One result item.
   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] body_byte;
      logic [CMD_W-1:0]  command_chars;
      logic [LEN_W-1:0]  declared_length;
      logic [ADDR_W-1:0] user_address;
      logic              checksum_ok;
      logic              too_short;
      logic              last_result;
   } rsp_item_type;

   // Up to two results written into the queue in one cycle, first one first.
   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_item_type first_item;
      rsp_item_type second_item;
   } push_type;

endpackage

@@ hw/rtl/xmfp_req_if.sv @@
interface xmfp_req_if;
   logic                       valid;
   logic                       ready;
   logic [xmfp_pkg::BYTE_W-1:0] data_byte;
   logic                       end_of_frame;

   modport source (output valid, output data_byte, output end_of_frame, input ready);
   modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

@@ hw/rtl/xmfp_rsp_if.sv @@
interface xmfp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [xmfp_pkg::BYTE_W-1:0] body_byte;
   logic [xmfp_pkg::CMD_W-1:0]  command_chars;
   logic [xmfp_pkg::LEN_W-1:0]  declared_length;
   logic [xmfp_pkg::ADDR_W-1:0] user_address;
   logic                        checksum_ok;
   logic                        too_short;
   logic                        last_result;

   modport source (output valid, output kind, output body_byte, output command_chars,
                   output declared_length, output user_address, output checksum_ok,
                   output too_short, output last_result, input ready);
   modport sink   (input valid, input kind, input body_byte, input command_chars,
                   input declared_length, input user_address, input checksum_ok,
                   input too_short, input last_result, output ready);
endinterface

@@ hw/rtl/xmfp_core.sv @@
`include "xor_message_frame_parser_unit_macros.svh"

module xmfp_core (
   input  logic               clock,
   input  logic               reset,
   xmfp_req_if.sink           req,
   input  logic               space_ok,
   output xmfp_pkg::push_type push
);
   import xmfp_pkg::*;

   logic              req_fire;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] held_byte_ff, held_byte_in;
   logic              held_valid_ff, held_valid_in;
   rsp_item_type      body_item;
   rsp_item_type      summary_item;

   // A request is taken whenever the result queue has room for two results.
   assign req.ready = space_ok;
   assign req_fire  = req.valid && space_ok;

   // Result built from the held body byte.
   always_comb begin
      body_item           = '0;
      body_item.kind      = KIND_BODY;
      body_item.body_byte = held_byte_ff;
   end

   // Summary result for the checksum byte now on the input.
   always_comb begin
      summary_item                 = '0;
      summary_item.kind            = KIND_SUMMARY;
      summary_item.command_chars   = cmd_ff;
      summary_item.declared_length = len_ff;
      summary_item.user_address    = addr_ff;
      summary_item.checksum_ok     = (xor_ff == req.data_byte);
      summary_item.too_short       = (pos_ff < POS_W'(MIN_FRAME - CSUM_BYTES));
      summary_item.last_result     = 1'b1;
   end

   // Frame state update and result selection.
   always_comb begin
      pos_in        = pos_ff;
      xor_in        = xor_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      addr_in       = addr_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      push          = '0;
      push.first_item  = body_item;
      push.second_item = summary_item;

      if (req_fire && !req.end_of_frame) begin
         if (pos_ff < POS_W'(HEADER_BYTES)) begin
            // Header bytes land in their fields, most significant byte first.
            for (int i = 0; i < CMD_BYTES; i++) begin
               if (pos_ff == POS_W'(i)) begin
                  cmd_in[(CMD_BYTES-1-i)*BYTE_W +: BYTE_W] = req.data_byte;
               end
            end
            for (int i = 0; i < LEN_BYTES; i++) begin
               if (pos_ff == POS_W'(CMD_BYTES + i)) begin
                  len_in[(LEN_BYTES-1-i)*BYTE_W +: BYTE_W] = req.data_byte;
               end
            end
            for (int i = 0; i < ADDR_BYTES; i++) begin
               if (pos_ff == POS_W'(CMD_BYTES + LEN_BYTES + i)) begin
                  addr_in[(ADDR_BYTES-1-i)*BYTE_W +: BYTE_W] = req.data_byte;
               end
            end
         end else begin
            // A body byte is released once the next byte shows it is not the checksum.
            push.first_valid = held_valid_ff;
            held_byte_in     = req.data_byte;
            held_valid_in    = 1'b1;
         end
         xor_in = xor_ff ^ req.data_byte;
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end else if (req_fire) begin
         // Checksum byte: flush the held body byte, then the summary.
         if (held_valid_ff) begin
            push.first_valid  = 1'b1;
            push.second_valid = 1'b1;
         end else begin
            push.first_valid = 1'b1;
            push.first_item  = summary_item;
         end
         pos_in        = '0;
         xor_in        = '0;
         cmd_in        = '0;
         len_in        = '0;
         addr_in       = '0;
         held_byte_in  = '0;
         held_valid_in = 1'b0;
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         xor_ff        <= '0;
         cmd_ff        <= '0;
         len_ff        <= '0;
         addr_ff       <= '0;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         xor_ff        <= xor_in;
         cmd_ff        <= cmd_in;
         len_ff        <= len_in;
         addr_ff       <= addr_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
      end
   end

   `XMFP_ASSERT_NEXT(a_frame_cleared, req_fire && req.end_of_frame, pos_ff == '0 && !held_valid_ff && xor_ff == '0)
   `XMFP_ASSERT_IMPLIES(a_held_after_header, held_valid_ff, pos_ff > POS_W'(HEADER_BYTES))
   `XMFP_ASSERT_IMPLIES(a_no_body_in_header, req_fire && pos_ff < POS_W'(HEADER_BYTES), !push.first_valid || push.first_item.kind == KIND_SUMMARY)

endmodule

@@ hw/rtl/xmfp_out_queue.sv @@
`include "xor_message_frame_parser_unit_macros.svh"

module xmfp_out_queue #(
   parameter int unsigned Depth = xmfp_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  xmfp_pkg::push_type push,
   output logic               space_ok,
   xmfp_rsp_if.source         rsp
);
   import xmfp_pkg::*;

   localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   rsp_item_type    entry_ff [Depth];
   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [IdxW-1:0] wr_next;
   logic            pop;
   rsp_item_type    head;

   function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] p);
      next_idx = (p == IdxW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   // Room for two results keeps a frame end from ever being refused midway.
   assign space_ok = (count_ff <= CntW'(Depth - 2));
   assign wr_next  = next_idx(wr_ptr_ff);

   // Head of the queue drives the result channel.
   assign head                = entry_ff[rd_ptr_ff];
   assign rsp.valid           = (count_ff != '0);
   assign rsp.kind            = head.kind;
   assign rsp.body_byte       = head.body_byte;
   assign rsp.command_chars   = head.command_chars;
   assign rsp.declared_length = head.declared_length;
   assign rsp.user_address    = head.user_address;
   assign rsp.checksum_ok     = head.checksum_ok;
   assign rsp.too_short       = head.too_short;
   assign rsp.last_result     = head.last_result;
   assign pop                 = rsp.valid && rsp.ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.second_valid) begin
         wr_ptr_in = next_idx(wr_next);
      end else if (push.first_valid) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = pop ? next_idx(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push.first_valid) + CntW'(push.second_valid)
                  - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; the second result goes one slot after the first.
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first_item;
      end
      if (push.second_valid) begin
         entry_ff[wr_next] <= push.second_item;
      end
   end

   `XMFP_ASSERT_HOLDS(a_count_bound, count_ff <= CntW'(Depth))
   `XMFP_ASSERT_IMPLIES(a_second_needs_first, push.second_valid, push.first_valid)
   `XMFP_ASSERT_IMPLIES(a_second_is_summary, push.second_valid, push.second_item.kind == KIND_SUMMARY && push.first_item.kind == KIND_BODY)

endmodule

@@ hw/rtl/xor_message_frame_parser_unit.sv @@
// Frame parser with XOR checksum check. One frame byte is taken per request, and a new request
// can be taken on every clock cycle while the result queue has room for two results. The first
// five bytes form the command, the next two a big-endian length and the next three a big-endian
// user address; later bytes are body bytes, each emitted as a result when the byte after it
// arrives, so the checksum byte (flagged by end_of_frame) is never emitted as body. The checksum
// request emits any held body byte and then a summary with the header fields, the checksum check
// and a short-frame flag (fewer than 11 bytes), after which the parser is ready for a new frame.
// Results reach the result channel through a registered queue of QueueDepth entries (at least
// 2); requests are taken while it has room for two results, so with the default depth of four
// and a result side that takes one result per cycle the parser sustains one byte per cycle,
// the two results of a frame end leaving one after the other.
module xor_message_frame_parser_unit #(
   parameter int unsigned QueueDepth = xmfp_pkg::DEFAULT_QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   xmfp_req_if.sink   req_ch,
   xmfp_rsp_if.source rsp_ch
);
   import xmfp_pkg::*;

   push_type push;
   logic     space_ok;

   // Header capture, checksum and body byte holding.
   xmfp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .space_ok (space_ok),
      .push     (push)
   );

   // Result queue between the parser and the result channel.
   xmfp_out_queue #(
      .Depth (QueueDepth)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_ch)
   );

endmodule

@@ verif/tb_xor_message_frame_parser_unit.sv @@
`timescale 1ns / 1ps

module tb_xor_message_frame_parser_unit;
   import xmfp_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 2_000_000;
   localparam int unsigned RANDOM_ITEMS     = 1800;
   localparam int unsigned HOLD_CYCLES      = 400;
   localparam int unsigned HOLD_AFTER_ITEMS = 300;
   localparam int unsigned MAX_REPORTS      = 10;
   localparam int unsigned TAIL_CYCLES      = 16;
   localparam logic [BYTE_W-1:0] FRAME_START = 8'h24;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_RANDOM,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   // One row of the directed table; a typed row carries its own frame summary.
   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              eof;
      bit                typed;
      rsp_item_type      summary;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   xmfp_req_if req_if ();
   xmfp_rsp_if rsp_if ();

   xor_message_frame_parser_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #5 clock = ~clock;

   // Frame tracking state of the predictor.
   logic [POS_W-1:0]  frame_pos;
   logic [BYTE_W-1:0] frame_xor;
   logic [CMD_W-1:0]  cmd_acc;
   logic [LEN_W-1:0]  len_acc;
   logic [ADDR_W-1:0] addr_acc;
   logic [BYTE_W-1:0] held_body;
   logic              held_body_valid;

   rsp_item_type expected_rsps[$];
   stim_row_type directed_rows[$];

   int unsigned failures = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned random_items = 0;
   bit          hold_request = 1'b0;
   bit          hold_done = 1'b0;
   logic [15:0] stall_pattern = '1;
   logic [3:0]  stall_idx = '0;

   function automatic rsp_item_type body_result(input logic [BYTE_W-1:0] b);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_BODY;
      r.body_byte = b;
      return r;
   endfunction

   function automatic rsp_item_type summary_result(input logic [CMD_W-1:0] cmd,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic ok, input logic short_frame);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_SUMMARY;
      r.command_chars = cmd;
      r.declared_length = len;
      r.user_address = addr;
      r.checksum_ok = ok;
      r.too_short = short_frame;
      r.last_result = 1'b1;
      return r;
   endfunction

   function automatic string item_text(input rsp_item_type r);
      return $sformatf("kind=%0d body=%02h cmd=%010h len=%04h addr=%06h ok=%0d short=%0d last=%0d",
                       r.kind, r.body_byte, r.command_chars, r.declared_length,
                       r.user_address, r.checksum_ok, r.too_short, r.last_result);
   endfunction

   task automatic clear_frame_state();
      frame_pos = '0;
      frame_xor = '0;
      cmd_acc = '0;
      len_acc = '0;
      addr_acc = '0;
      held_body = '0;
      held_body_valid = 1'b0;
   endtask

   // Advance the frame state by one accepted request and queue the results it causes.
   task automatic parse_byte(input logic [BYTE_W-1:0] d, input logic eof);
      if (!eof) begin
         if (frame_pos < CMD_BYTES) begin
            cmd_acc = cmd_acc | (CMD_W'(d) << ((CMD_BYTES - 1 - frame_pos) * 8));
         end else if (frame_pos < CMD_BYTES + LEN_BYTES) begin
            len_acc = len_acc | (LEN_W'(d) << ((CMD_BYTES + LEN_BYTES - 1 - frame_pos) * 8));
         end else if (frame_pos < HEADER_BYTES) begin
            addr_acc = addr_acc | (ADDR_W'(d) << ((HEADER_BYTES - 1 - frame_pos) * 8));
         end else begin
            // Body bytes go out one request late.
            if (held_body_valid) begin
               expected_rsps.push_back(body_result(held_body));
            end
            held_body = d;
            held_body_valid = 1'b1;
         end
         frame_xor = frame_xor ^ d;
         if (frame_pos != POS_MAX) begin
            frame_pos = frame_pos + 1'b1;
         end
      end else begin
         // Checksum byte: flush the held body byte, then the summary.
         if (held_body_valid) begin
            expected_rsps.push_back(body_result(held_body));
         end
         expected_rsps.push_back(summary_result(cmd_acc, len_acc, addr_acc, frame_xor == d,
                                                (32'(frame_pos) + CSUM_BYTES) < MIN_FRAME));
         clear_frame_state();
      end
   endtask

   // Offer one request, with bursts and random gaps, and predict once it is taken.
   task automatic offer_byte(input logic [BYTE_W-1:0] d, input logic eof, input bit typed,
                             input rsp_item_type summary);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= d;
      req_if.end_of_frame <= eof;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      parse_byte(d, eof);
      if (typed) begin
         void'(expected_rsps.pop_back());
         expected_rsps.push_back(summary);
      end
   endtask

   // Send a frame of n_bytes, the checksum included, with random content.
   task automatic send_frame(input int unsigned n_bytes, input bit good_sum);
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] sum;
      int unsigned i;
      sum = '0;
      for (i = 1; i < n_bytes; i++) begin
         b = BYTE_W'($urandom);
         if (i == 1 && $urandom_range(0, 1) == 1) begin
            b = FRAME_START;
         end
         sum = sum ^ b;
         offer_byte(b, 1'b0, 1'b0, '0);
      end
      if (!good_sum) begin
         sum = sum ^ BYTE_W'($urandom_range(1, 255));
      end
      offer_byte(sum, 1'b1, 1'b0, '0);
   endtask

   task automatic report_failure(input string what, input rsp_item_type want,
                                 input rsp_item_type got);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, what);
         $display("   expected %s", item_text(want));
         $display("   actual   %s", item_text(got));
      end
   endtask

   // Result side: stall on a rotating pattern, with one long hold-off on request.
   initial begin
      stall_mode_type mode;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            if (stall_idx == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               case (mode)
                  STALL_NONE:   stall_pattern = '1;
                  STALL_RANDOM: stall_pattern = 16'($urandom);
                  STALL_LIGHT:  stall_pattern = 16'($urandom | $urandom);
                  default:      stall_pattern = 16'($urandom & $urandom);
               endcase
            end
            rsp_if.ready <= stall_pattern[stall_idx];
            stall_idx = stall_idx + 1'b1;
         end
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{kind: rsp_if.kind, body_byte: rsp_if.body_byte,
                 command_chars: rsp_if.command_chars, declared_length: rsp_if.declared_length,
                 user_address: rsp_if.user_address, checksum_ok: rsp_if.checksum_ok,
                 too_short: rsp_if.too_short, last_result: rsp_if.last_result};
         if (expected_rsps.size() == 0) begin
            report_failure("result with no request waiting for it", '0, got);
         end else begin
            want = expected_rsps.pop_front();
            if (got.kind !== want.kind || got.body_byte !== want.body_byte ||
                got.command_chars !== want.command_chars ||
                got.declared_length !== want.declared_length ||
                got.user_address !== want.user_address ||
                got.checksum_ok !== want.checksum_ok || got.too_short !== want.too_short ||
                got.last_result !== want.last_result) begin
               report_failure("result mismatch", want, got);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int unsigned n;
      int unsigned pick;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data_byte <= '0;
      req_if.end_of_frame <= 1'b0;
      clear_frame_state();

      // Directed part: lone checksum bytes, an all-ones minimum frame, one body byte.
      directed_rows.push_back('{8'h00, 1'b1, 1'b1, summary_result('0, '0, '0, 1'b1, 1'b1)});
      directed_rows.push_back('{8'hFF, 1'b1, 1'b1, summary_result('0, '0, '0, 1'b0, 1'b1)});
      repeat (HEADER_BYTES) directed_rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h00, 1'b1, 1'b1,
                                summary_result('1, '1, '1, 1'b1, 1'b0)});
      directed_rows.push_back('{FRAME_START, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h54, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h58, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h53, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h51, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h0C, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h80, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h01, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h5A, 1'b1, 1'b0, '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].data, directed_rows[i].eof, directed_rows[i].typed,
                    directed_rows[i].summary);
      end

      // Random part: mostly well-formed frames, some short and some with a bad checksum.
      while (random_items < RANDOM_ITEMS) begin
         if (!hold_request && random_items >= HOLD_AFTER_ITEMS) begin
            hold_request = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            n = $urandom_range(1, MIN_FRAME - 1);
         end else if (pick < 85) begin
            n = $urandom_range(MIN_FRAME, 40);
         end else begin
            n = $urandom_range(41, 120);
         end
         send_frame(n, $urandom_range(0, 9) < 7);
         random_items += n;
      end
      req_if.valid <= 1'b0;

      // Drain the outstanding results, then let the block settle.
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         $display("%0d expected results never arrived", expected_rsps.size());
         failures += expected_rsps.size();
      end
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
